>>> rtl/nav_variance_failsafe_monitor_top_assert.svh
// assertion macros for the nav variance failsafe monitor
// no dependencies; included by the top level
`ifndef NAV_VARIANCE_FAILSAFE_MONITOR_TOP_ASSERT_SVH
`define NAV_VARIANCE_FAILSAFE_MONITOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// condition must hold on every edge outside reset
`define NVFM_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("nvfm assertion failed");

// antecedent implies consequent on the same edge
`define NVFM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nvfm assertion failed");

`else

`define NVFM_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define NVFM_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/nvfm_pkg.sv
// shared types and constants for the nav variance failsafe monitor
// used by nvfm_core and nav_variance_failsafe_monitor_top
package nvfm_pkg;

   // fail counter limit and derived counter width
   localparam int FAIL_LIMIT = 10;
   localparam int CNT_W      = $clog2(FAIL_LIMIT + 1);

   typedef logic [CNT_W-1:0] cnt_type;

   localparam cnt_type CNT_LIMIT = cnt_type'(FAIL_LIMIT);
   localparam cnt_type CNT_YAW   = cnt_type'(FAIL_LIMIT - 2);
   localparam cnt_type CNT_LANE  = cnt_type'(FAIL_LIMIT - 1);

   // register reset values
   localparam logic [15:0] RST_FAIL_THRESHOLD    = 16'd205;
   localparam logic        RST_QUADPLANE_ENABLED = 1'b1;
   localparam logic [31:0] RST_WARN_INTERVAL_MS  = 32'd30000;

   // register indexes
   typedef enum logic [1:0] {
      CSR_FAIL_THRESHOLD    = 2'd0,
      CSR_QUADPLANE_ENABLED = 2'd1,
      CSR_WARN_INTERVAL_MS  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE        = 2'd0,
      EV_BAD_LATCHED = 2'd1,
      EV_CLEARED     = 2'd2
   } event_code_type;

   typedef enum logic [1:0] {
      FS_NONE     = 2'd0,
      FS_ENTERED  = 2'd1,
      FS_RESOLVED = 2'd2
   } fs_change_type;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_LAND  = 2'd1,
      MODE_HOVER = 2'd2
   } mode_req_type;

   typedef struct packed {
      logic [15:0] fail_threshold;
      logic        quadplane_enabled;
      logic [31:0] warn_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic        origin_valid;
      logic        armed;
      logic        vtol_posvel_mode;
      logic        vtol_auto;
      logic        variances_valid;
      logic [15:0] vel_var;
      logic [15:0] pos_variance;
      logic [15:0] mag_x;
      logic [15:0] mag_y;
      logic [15:0] mag_z;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      cnt_type     fail_counter;
      logic        bad_latch;
      logic [31:0] last_warn_ms;
      logic        failsafe_latch;
   } state_type;

   typedef struct packed {
      logic           variance_bad;
      logic           yaw_reset_req;
      logic           lane_switch_req;
      logic           warn_pulse;
      event_code_type event_code;
      fs_change_type  failsafe_change;
      mode_req_type   mode_request;
      logic           failsafe_active;
   } result_type;

endpackage

>>> rtl/nvfm_core.sv
// per-tick scoring and fail counter update, purely combinational
// depends on nvfm_pkg
module nvfm_core (
   input  nvfm_pkg::cfg_type    cfg,
   input  nvfm_pkg::item_type   item,
   input  nvfm_pkg::state_type  state,
   output nvfm_pkg::state_type  state_nxt,
   output nvfm_pkg::result_type result
);
   import nvfm_pkg::*;

   logic [15:0] mag_ab;
   logic [15:0] mag_max;
   logic        mag_hit;
   logic        vel_hit;
   logic        vel_hit2;
   logic        pos_hit;
   logic        score_ge1;
   logic        score_ge2;
   logic        over;
   logic        disabled;
   cnt_type     cnt_inc;
   cnt_type     cnt_dec;
   logic [31:0] since_warn;

   // variance scoring against the threshold
   always_comb begin
      mag_ab    = (item.mag_x > item.mag_y) ? item.mag_x : item.mag_y;
      mag_max   = (mag_ab > item.mag_z) ? mag_ab : item.mag_z;
      mag_hit   = mag_max >= cfg.fail_threshold;
      vel_hit   = item.vel_var >= cfg.fail_threshold;
      vel_hit2  = {1'b0, item.vel_var} >= {cfg.fail_threshold, 1'b0};
      pos_hit   = item.pos_variance >= cfg.fail_threshold;
      score_ge1 = mag_hit || vel_hit;
      score_ge2 = vel_hit2 || (mag_hit && vel_hit);
      over      = (cfg.fail_threshold != 16'd0) && item.variances_valid &&
                  ((pos_hit && score_ge1) || score_ge2);
      disabled  = !item.armed || (cfg.fail_threshold == 16'd0) ||
                  (cfg.quadplane_enabled && !item.vtol_posvel_mode);
   end

   // counter arithmetic and warning throttle
   assign cnt_inc    = state.fail_counter + cnt_type'(1);
   assign cnt_dec    = state.fail_counter - cnt_type'(1);
   assign since_warn = item.now_ms - state.last_warn_ms;

   // next state and result for one tick
   always_comb begin
      state_nxt              = state;
      result.yaw_reset_req   = 1'b0;
      result.lane_switch_req = 1'b0;
      result.warn_pulse      = 1'b0;
      result.event_code      = EV_NONE;
      result.failsafe_change = FS_NONE;
      result.mode_request    = MODE_NONE;

      if (item.origin_valid) begin
         if (disabled) begin
            state_nxt.fail_counter = '0;
            state_nxt.bad_latch    = 1'b0;
            if (state.failsafe_latch) begin
               state_nxt.failsafe_latch = 1'b0;
               result.failsafe_change   = FS_RESOLVED;
            end
         end else if (over) begin
            if (!state.bad_latch) begin
               state_nxt.fail_counter = cnt_inc;
               result.yaw_reset_req   = (cnt_inc == CNT_YAW);
               result.lane_switch_req = (cnt_inc == CNT_LANE);
               if (cnt_inc >= CNT_LIMIT) begin
                  state_nxt.fail_counter = CNT_LIMIT;
                  state_nxt.bad_latch    = 1'b1;
                  result.event_code      = EV_BAD_LATCHED;
                  if (since_warn > cfg.warn_interval_ms) begin
                     result.warn_pulse      = 1'b1;
                     state_nxt.last_warn_ms = item.now_ms;
                  end
                  if (!state.failsafe_latch) begin
                     state_nxt.failsafe_latch = 1'b1;
                     result.failsafe_change   = FS_ENTERED;
                     if (cfg.quadplane_enabled && item.vtol_posvel_mode) begin
                        result.mode_request = item.vtol_auto ? MODE_LAND : MODE_HOVER;
                     end
                  end
               end
            end
         end else if (state.fail_counter != '0) begin
            // hysteresis: count down, clear latches on reaching zero
            state_nxt.fail_counter = cnt_dec;
            if (state.bad_latch && (cnt_dec == '0)) begin
               state_nxt.bad_latch = 1'b0;
               result.event_code   = EV_CLEARED;
               if (state.failsafe_latch) begin
                  state_nxt.failsafe_latch = 1'b0;
                  result.failsafe_change   = FS_RESOLVED;
               end
            end
         end
      end

      result.variance_bad    = state_nxt.bad_latch;
      result.failsafe_active = state_nxt.failsafe_latch;
   end

endmodule

>>> rtl/nav_variance_failsafe_monitor_top.sv
// nav variance failsafe monitor: a req beat goes through the input and result registers
// throughput one tick per cycle unless rsp_stall holds the pipeline; the input register
// feeds the scoring logic and the fail counter/latch update into the result register
// synchronous active-high reset clears valids and the monitor state and
// loads the register defaults (threshold 205, quadplane on, 30000 ms)
// depends on nvfm_pkg, nvfm_core and the assertion macro header
`include "nav_variance_failsafe_monitor_top_assert.svh"

module nav_variance_failsafe_monitor_top (
   input  logic                     clock,
   input  logic                     reset,
   // configuration write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_wdata,
   // tick input channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_origin_valid,
   input  logic                     req_armed,
   input  logic                     req_vtol_posvel_mode,
   input  logic                     req_vtol_auto,
   input  logic                     req_variances_valid,
   input  logic [15:0]              req_vel_var,
   input  logic [15:0]              req_pos_variance,
   input  logic [15:0]              req_mag_x,
   input  logic [15:0]              req_mag_y,
   input  logic [15:0]              req_mag_z,
   input  logic [31:0]              req_now_ms,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_variance_bad,
   output logic                     rsp_yaw_reset_req,
   output logic                     rsp_lane_switch_req,
   output logic                     rsp_warn_pulse,
   output nvfm_pkg::event_code_type rsp_event_code,
   output nvfm_pkg::fs_change_type  rsp_failsafe_change,
   output nvfm_pkg::mode_req_type   rsp_mode_request,
   output logic                     rsp_failsafe_active
);
   import nvfm_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff, s1_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff, out_res_in;
   state_type  state_ff, state_in;
   state_type  state_nxt;
   result_type core_res;
   logic       advance;
   logic       req_beat;

   // configuration writes, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FAIL_THRESHOLD:    cfg_in.fail_threshold    = csr_wdata[15:0];
            CSR_QUADPLANE_ENABLED: cfg_in.quadplane_enabled = csr_wdata[0];
            CSR_WARN_INTERVAL_MS:  cfg_in.warn_interval_ms  = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // pipeline flow control
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_beat  = req_valid && !req_stall;

   always_comb begin
      s1_item_in   = s1_item_ff;
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      state_in     = state_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
         if (s1_valid_ff) begin
            out_res_in = core_res;
            state_in   = state_nxt;
         end
      end
      if (req_beat) begin
         s1_valid_in = 1'b1;
         s1_item_in  = '{
            origin_valid:     req_origin_valid,
            armed:            req_armed,
            vtol_posvel_mode: req_vtol_posvel_mode,
            vtol_auto:        req_vtol_auto,
            variances_valid:  req_variances_valid,
            vel_var:          req_vel_var,
            pos_variance:     req_pos_variance,
            mag_x:            req_mag_x,
            mag_y:            req_mag_y,
            mag_z:            req_mag_z,
            now_ms:           req_now_ms
         };
      end
   end

   // scoring and state update
   nvfm_core u_core (
      .cfg       (cfg_ff),
      .item      (s1_item_ff),
      .state     (state_ff),
      .state_nxt (state_nxt),
      .result    (core_res)
   );

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fail_threshold    <= RST_FAIL_THRESHOLD;
         cfg_ff.quadplane_enabled <= RST_QUADPLANE_ENABLED;
         cfg_ff.warn_interval_ms  <= RST_WARN_INTERVAL_MS;
         s1_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
         state_ff                 <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      out_res_ff <= out_res_in;
   end

   // result beat outputs
   assign rsp_valid           = out_valid_ff;
   assign rsp_variance_bad    = out_res_ff.variance_bad;
   assign rsp_yaw_reset_req   = out_res_ff.yaw_reset_req;
   assign rsp_lane_switch_req = out_res_ff.lane_switch_req;
   assign rsp_warn_pulse      = out_res_ff.warn_pulse;
   assign rsp_event_code      = out_res_ff.event_code;
   assign rsp_failsafe_change = out_res_ff.failsafe_change;
   assign rsp_mode_request    = out_res_ff.mode_request;
   assign rsp_failsafe_active = out_res_ff.failsafe_active;

   // invariants of the fail counter and latches
   `NVFM_ASSERT_ALWAYS(a_cnt_bounded, clock, reset, state_ff.fail_counter <= CNT_LIMIT)
   `NVFM_ASSERT_IMPLY(a_fs_needs_bad, clock, reset, state_ff.failsafe_latch, state_ff.bad_latch)
   `NVFM_ASSERT_IMPLY(a_bad_needs_cnt, clock, reset, state_ff.bad_latch, state_ff.fail_counter != '0)
   `NVFM_ASSERT_IMPLY(a_latch_evt_flag, clock, reset, out_valid_ff && (out_res_ff.event_code == EV_BAD_LATCHED), out_res_ff.variance_bad)

endmodule
